// File: sv/midpoint_ellipse_raster_unit_macros.svh
// Assertion macros for the midpoint ellipse raster unit.
// Used by the modules that carry assertions; expects clk and rst_n in scope.
`ifndef MIDPOINT_ELLIPSE_RASTER_UNIT_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTER_UNIT_MACROS_SVH

// same-cycle implication
`define MER_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MER_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mer_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the midpoint ellipse raster unit.
// No dependencies.
package mer_pkg;

  localparam int AXIS_BITS_DEF  = 10;
  localparam int COORD_BITS_DEF = 11;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  localparam logic [1:0] EMIT_LAST = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A2,
    ST_B2,
    ST_AB,
    ST_INIT,
    ST_STEP,
    ST_BX,
    ST_AY,
    ST_UPD,
    ST_BTX,
    ST_SQ1,
    ST_ATY,
    ST_SQ2,
    ST_ABM,
    ST_SQ3,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_AA,
    MUL_BB,
    MUL_A2B,
    MUL_B2X,
    MUL_A2Y,
    MUL_BTX,
    MUL_ATY,
    MUL_AB,
    MUL_SQ
  } mul_sel_t;

  typedef enum logic [2:0] {
    DEC_NONE,
    DEC_INIT,
    DEC_STEP,
    DEC_SET,
    DEC_ADD4,
    DEC_SUB4
  } dec_op_t;

  typedef struct packed {
    logic       load;
    logic       step_xy;
    mul_sel_t   mul_sel;
    logic       cap_a2;
    logic       cap_b2;
    logic       cap_bx;
    dec_op_t    dec_op;
    logic       set_r2;
    logic       emit_ld;
    logic [1:0] emit_idx;
    logic       fin;
  } dp_cmd_t;

  typedef struct packed {
    logic y_zero;
    logic switch_go;
  } dp_sts_t;

endpackage

// File: sv/midpoint_ellipse_raster_unit.sv
`timescale 1ns / 1ps
// Midpoint ellipse rasteriser. A start item (func 0) latches centre and semi-axes
// and yields the four mirrored pixels of (0, semi_y); each advance item (func 1)
// takes one midpoint step and yields the four mirrored pixels of the new point,
// the fourth marked last_pixel, all marked finished once y reaches 0. Advance
// items on a finished or idle outline are taken and yield nothing. All products
// go one a cycle through a single shared multiplier, which sets the cost: a
// start forms a^2, b^2, a^2*b and the initial decision, an advance steps the
// point, forms b^2*x and a^2*y and updates the decision, and the step that moves
// into region 2 also rebuilds the decision for region 2; then pixels go one per
// cycle into the output register, held while a pixel waits there and out_ready
// is low. Input is taken only between items; the last pixel of one item may
// still wait in the output register.
// Depends on mer_pkg, mer_ctrl and mer_datapath.
module midpoint_ellipse_raster_unit #(
  parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [COORD_BITS-1:0]        in_center_x,
  input  logic [COORD_BITS-1:0]        in_center_y,
  input  logic [AXIS_BITS-1:0]         in_semi_x,
  input  logic [AXIS_BITS-1:0]         in_semi_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS+1:0] out_pixel_x,
  output logic signed [COORD_BITS+1:0] out_pixel_y,
  output logic                         out_last_pixel,
  output logic                         out_finished
);
  import mer_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mer_datapath #(
    .AXIS_BITS  (AXIS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_semi_x      (in_semi_x),
    .in_semi_y      (in_semi_y),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel),
    .out_finished   (out_finished)
  );

endmodule

// File: sv/mer_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the midpoint ellipse raster unit: handshakes, step order, emit.
// Depends on mer_pkg and midpoint_ellipse_raster_unit_macros.svh.
`include "midpoint_ellipse_raster_unit_macros.svh"

module mer_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_func,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output mer_pkg::dp_cmd_t cmd,
  input  mer_pkg::dp_sts_t sts
);
  import mer_pkg::*;

  state_t     state_r, state_nxt;
  logic       active_r, active_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  assign ld = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = ld ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_START) begin
            cmd.load  = 1'b1;
            state_nxt = ST_A2;
          end else if (active_r) begin
            state_nxt = ST_STEP;
          end
        end
      end
      ST_A2: begin
        cmd.mul_sel = MUL_AA;
        state_nxt   = ST_B2;
      end
      ST_B2: begin
        cmd.mul_sel = MUL_BB;
        cmd.cap_a2  = 1'b1;
        state_nxt   = ST_AB;
      end
      ST_AB: begin
        cmd.mul_sel = MUL_A2B;
        cmd.cap_b2  = 1'b1;
        state_nxt   = ST_INIT;
      end
      ST_INIT: begin
        cmd.dec_op = DEC_INIT;
        active_nxt = !sts.y_zero;
        state_nxt  = ST_EMIT;
      end
      ST_STEP: begin
        cmd.step_xy = 1'b1;
        state_nxt   = ST_BX;
      end
      ST_BX: begin
        cmd.mul_sel = MUL_B2X;
        state_nxt   = ST_AY;
      end
      ST_AY: begin
        cmd.mul_sel = MUL_A2Y;
        cmd.cap_bx  = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        cmd.dec_op = DEC_STEP;
        if (sts.y_zero) begin
          active_nxt = 1'b0;
          state_nxt  = ST_EMIT;
        end else if (sts.switch_go) begin
          state_nxt = ST_BTX;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      // region 2 entry: (b*tx)^2 + 4(a*ty)^2 - 4(a*b)^2
      ST_BTX: begin
        cmd.mul_sel = MUL_BTX;
        state_nxt   = ST_SQ1;
      end
      ST_SQ1: begin
        cmd.mul_sel = MUL_SQ;
        state_nxt   = ST_ATY;
      end
      ST_ATY: begin
        cmd.mul_sel = MUL_ATY;
        cmd.dec_op  = DEC_SET;
        state_nxt   = ST_SQ2;
      end
      ST_SQ2: begin
        cmd.mul_sel = MUL_SQ;
        state_nxt   = ST_ABM;
      end
      ST_ABM: begin
        cmd.mul_sel = MUL_AB;
        cmd.dec_op  = DEC_ADD4;
        state_nxt   = ST_SQ3;
      end
      ST_SQ3: begin
        cmd.mul_sel = MUL_SQ;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        cmd.dec_op = DEC_SUB4;
        cmd.set_r2 = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_ld  = ld;
        cmd.emit_idx = cnt_r;
        cmd.fin      = !active_r;
        if (ld) begin
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == EMIT_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `MER_ASSERT_IMP(a_valid_from_emit, $rose(out_valid_r), $past(state_r) == ST_EMIT,
                  "result valid raised outside emit")
  `MER_ASSERT_NXT(a_drop_when_done,
                  in_valid && in_ready && (in_func == FUNC_ADVANCE) && !active_r,
                  state_r == ST_IDLE, "advance on finished outline started work")
  `MER_ASSERT_NXT(a_end_clears_active, (state_r == ST_UPD) && sts.y_zero, !active_r,
                  "outline end did not clear active")
  `MER_ASSERT_NXT(a_entry_to_emit, state_r == ST_FIN, state_r == ST_EMIT,
                  "region 2 entry did not go on to emit")

endmodule

// File: sv/mer_datapath.sv
`timescale 1ns / 1ps
// Datapath of the midpoint ellipse raster unit: operands, shared multiplier,
// decision accumulator, point and pixel output registers. Depends on mer_pkg.
module mer_datapath #(
  parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  mer_pkg::dp_cmd_t              cmd,
  output mer_pkg::dp_sts_t              sts,
  input  logic [COORD_BITS-1:0]         in_center_x,
  input  logic [COORD_BITS-1:0]         in_center_y,
  input  logic [AXIS_BITS-1:0]          in_semi_x,
  input  logic [AXIS_BITS-1:0]          in_semi_y,
  output logic signed [COORD_BITS+1:0]  out_pixel_x,
  output logic signed [COORD_BITS+1:0]  out_pixel_y,
  output logic                          out_last_pixel,
  output logic                          out_finished
);
  import mer_pkg::*;

  localparam int MW    = 2 * AXIS_BITS + 1;
  localparam int PW    = 2 * MW;
  localparam int DW    = 4 * AXIS_BITS + 4;
  localparam int PIX_W = COORD_BITS + 2;

  logic [COORD_BITS-1:0]  cx_r, cy_r;
  logic [AXIS_BITS-1:0]   a_r, b_r, x_r, y_r;
  logic [2*AXIS_BITS-1:0] a2_r, b2_r;
  logic [3*AXIS_BITS-1:0] bx_r;
  logic [PW-1:0]          prod_r;
  logic [DW-1:0]          dec_r, dec_nxt;
  logic                   r2_r, se_r;
  logic [PIX_W-1:0]       px_r, py_r;
  logic                   last_r, fin_r;

  logic [MW-1:0]          op_a, op_b;
  logic [PW-1:0]          mul_res;
  logic [AXIS_BITS-1:0]   x_inc;
  logic                   dec_pos, se_now;
  logic                   use_bx, use_ay;
  logic [PIX_W-1:0]       cx_e, cy_e, x_e, y_e;

  assign dec_pos = !dec_r[DW-1] && (dec_r != '0);
  assign x_inc   = (x_r == '1) ? x_r : x_r + 1'b1;
  assign se_now  = r2_r ? !dec_pos : dec_pos;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      MUL_AA:  begin op_a = MW'(a_r);  op_b = MW'(a_r); end
      MUL_BB:  begin op_a = MW'(b_r);  op_b = MW'(b_r); end
      MUL_A2B: begin op_a = MW'(a2_r); op_b = MW'(b_r); end
      MUL_B2X: begin op_a = MW'(b2_r); op_b = MW'(x_r); end
      MUL_A2Y: begin op_a = MW'(a2_r); op_b = MW'(y_r); end
      MUL_BTX: begin op_a = MW'(b_r);  op_b = MW'({x_r, 1'b1}); end
      MUL_ATY: begin op_a = MW'(a_r);  op_b = MW'(y_r - 1'b1); end
      MUL_AB:  begin op_a = MW'(a_r);  op_b = MW'(b_r); end
      MUL_SQ:  begin op_a = prod_r[MW-1:0]; op_b = prod_r[MW-1:0]; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign mul_res = PW'(op_a) * PW'(op_b);

  // region 1 adds 4b^2, region 2 adds 4a^2; x and y terms as the move requires
  assign use_bx = !r2_r || se_r;
  assign use_ay = r2_r || se_r;

  always_comb begin
    dec_nxt = dec_r;
    case (cmd.dec_op)
      DEC_INIT: dec_nxt = (DW'(b2_r) << 2) - (DW'(prod_r) << 2) + DW'(a2_r);
      DEC_STEP: dec_nxt = dec_r
                          + (r2_r ? (DW'(a2_r) << 2) : (DW'(b2_r) << 2))
                          + (use_bx ? (DW'(bx_r) << 3) : '0)
                          - (use_ay ? (DW'(prod_r) << 3) : '0);
      DEC_SET:  dec_nxt = DW'(prod_r);
      DEC_ADD4: dec_nxt = dec_r + (DW'(prod_r) << 2);
      DEC_SUB4: dec_nxt = dec_r - (DW'(prod_r) << 2);
      default:  dec_nxt = dec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r <= in_center_x;
      cy_r <= in_center_y;
      a_r  <= in_semi_x;
      b_r  <= in_semi_y;
      x_r  <= '0;
      y_r  <= in_semi_y;
      r2_r <= 1'b0;
    end else begin
      if (cmd.step_xy) begin
        se_r <= se_now;
        if (r2_r) begin
          y_r <= y_r - 1'b1;
          if (se_now) x_r <= x_inc;
        end else begin
          x_r <= x_inc;
          if (se_now) y_r <= y_r - 1'b1;
        end
      end
      if (cmd.set_r2) r2_r <= 1'b1;
    end
    if (cmd.mul_sel != MUL_NONE) prod_r <= mul_res;
    if (cmd.cap_a2) a2_r <= prod_r[2*AXIS_BITS-1:0];
    if (cmd.cap_b2) b2_r <= prod_r[2*AXIS_BITS-1:0];
    if (cmd.cap_bx) bx_r <= prod_r[3*AXIS_BITS-1:0];
    dec_r <= dec_nxt;
  end

  assign sts.y_zero    = (y_r == '0);
  assign sts.switch_go = !r2_r && (PW'(bx_r) > prod_r);

  assign cx_e = PIX_W'(cx_r);
  assign cy_e = PIX_W'(cy_r);
  assign x_e  = PIX_W'(x_r);
  assign y_e  = PIX_W'(y_r);

  // item order: (+x,+y) (-x,+y) (+x,-y) (-x,-y)
  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      px_r   <= cmd.emit_idx[0] ? cx_e - x_e : cx_e + x_e;
      py_r   <= cmd.emit_idx[1] ? cy_e - y_e : cy_e + y_e;
      last_r <= (cmd.emit_idx == EMIT_LAST);
      fin_r  <= cmd.fin;
    end
  end

  assign out_pixel_x    = px_r;
  assign out_pixel_y    = py_r;
  assign out_last_pixel = last_r;
  assign out_finished   = fin_r;

endmodule
